>>> design/tw_pkg.sv
// shared types and constants for the trapezoid waveform and area block
package tw_pkg;

    localparam int TIME_W     = 32;
    localparam int START_W    = 31;
    localparam int DUR_W      = 24;
    localparam int LVL_W      = 24;
    localparam int AREA_W     = 56;
    localparam int PROD_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLAT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK  = 3'd4;

    typedef enum logic [2:0] {
        SEG_ZERO,
        SEG_RISE,
        SEG_PLAT,
        SEG_FALL,
        SEG_DONE
    } t_seg;

    typedef struct packed {
        logic [TIME_W-1:0]  t0;
        logic [TIME_W-1:0]  t1;
        logic [TIME_W-1:0]  t2;
        logic [TIME_W-1:0]  t3;
        logic [DUR_W-1:0]   rise;
        logic [DUR_W-1:0]   fall;
        logic [LVL_W-1:0]   mag;
        logic               neg;
        logic               f_zero;
        logic [PROD_W-2:0]  half_ar;
        logic [PROD_W:0]    base;
    } t_cfg;

    typedef struct packed {
        t_seg               seg;
        logic [DUR_W-1:0]   d;
        logic [PROD_W-1:0]  ad;
    } t_side_a;

    typedef struct packed {
        t_seg               seg;
        logic [LVL_W-1:0]   quo;
        logic               nz;
        logic [PROD_W-2:0]  hdq;
        logic [PROD_W-1:0]  ad;
    } t_side_b;

endpackage

>>> design/trapezoid_waveform_and_area.sv
// top level: trapezoid pulse amplitude and running area, one query per cycle
//
//  channel   ports                                   handshake
//  query     i_start, o_busy, i_query_time           taken when i_start & !o_busy
//  result    o_valid, o_amplitude, o_area            one-cycle strobe on o_valid
//  config    i_cfg_we, i_cfg_idx, i_cfg_data         write when i_cfg_we is high
//
// a query can enter every cycle that i_start is high; o_busy is tied low
// the two divider pipelines have 24 stages each
// reset is synchronous on i_rst_n and clears valid bits and config registers, not data path registers
// the receiver cannot stall, so the pipeline never holds
module trapezoid_waveform_and_area (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [tw_pkg::TIME_W-1:0]     i_query_time,
    output logic                          o_valid,
    output logic signed [tw_pkg::LVL_W-1:0]  o_amplitude,
    output logic signed [tw_pkg::AREA_W-1:0] o_area,
    input  logic                          i_cfg_we,
    input  logic [tw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tw_pkg::*;

    localparam int SA_W = $bits(t_side_a);
    localparam int SB_W = $bits(t_side_b);

    t_cfg cfg;

    tw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign o_busy = 1'b0;

    // beat capture
    logic              r0_v;
    logic [TIME_W-1:0] r0_q;
    // segment decode
    logic              r1_v;
    logic [TIME_W-1:0] r1_q;
    t_seg              r1_seg;
    t_seg              n1_seg;
    // offset and divisor
    logic              r2_v;
    t_seg              r2_seg;
    logic [DUR_W-1:0]  r2_d, r2_den;
    logic [DUR_W-1:0]  n2_d, n2_den;
    logic [TIME_W-1:0] n2_diff;
    // a*d
    logic              r3_v;
    t_side_a           r3_side;
    logic [DUR_W-1:0]  r3_den;

    always_comb begin
        if (r0_q <= cfg.t0) begin
            n1_seg = SEG_ZERO;
        end else if (r0_q <= cfg.t1) begin
            n1_seg = SEG_RISE;
        end else if (r0_q <= cfg.t2) begin
            n1_seg = SEG_PLAT;
        end else if (r0_q <= cfg.t3) begin
            n1_seg = SEG_FALL;
        end else begin
            n1_seg = SEG_DONE;
        end
    end

    always_comb begin
        n2_den  = cfg.fall;
        n2_diff = '0;
        n2_d    = '0;
        case (r1_seg)
            SEG_RISE: begin
                n2_diff = r1_q - cfg.t0;
                n2_d    = n2_diff[DUR_W-1:0];
                n2_den  = cfg.rise;
            end
            SEG_PLAT: begin
                n2_diff = r1_q - cfg.t1;
                n2_d    = n2_diff[DUR_W-1:0];
            end
            SEG_FALL: begin
                n2_diff = r1_q - cfg.t2;
                n2_d    = n2_diff[DUR_W-1:0];
            end
            SEG_DONE: n2_d = cfg.fall;
            default:  n2_d = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r0_q            <= i_query_time;
        r1_q            <= r0_q;
        r1_seg          <= n1_seg;
        r2_seg          <= r1_seg;
        r2_d            <= n2_d;
        r2_den          <= n2_den;
        r3_side.seg     <= r2_seg;
        r3_side.d       <= r2_d;
        r3_side.ad      <= PROD_W'(cfg.mag) * PROD_W'(r2_d);
        r3_den          <= r2_den;
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r0_v <= i_start & ~o_busy;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // first division: q, r = divmod(a*d, den)
    logic              da_v;
    logic [LVL_W-1:0]  da_quo;
    logic [DUR_W-1:0]  da_rem, da_den;
    logic [SA_W-1:0]   da_side_bits;
    t_side_a           da_side;

    tw_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (DUR_W),
        .Q_W    (LVL_W),
        .SIDE_W (SA_W)
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_num   (r3_side.ad),
        .i_den   (r3_den),
        .i_side  (SA_W'(r3_side)),
        .o_valid (da_v),
        .o_quo   (da_quo),
        .o_rem   (da_rem),
        .o_den   (da_den),
        .o_side  (da_side_bits)
    );

    assign da_side = t_side_a'(da_side_bits);

    // d*q and d*r, then the numerator of the squared-term correction
    logic              r4_v;
    t_seg              r4_seg;
    logic [LVL_W-1:0]  r4_quo;
    logic              r4_nz;
    logic [PROD_W-1:0] r4_dq, r4_dr, r4_ad;
    logic [DUR_W-1:0]  r4_den;

    logic              r5_v;
    t_side_b           r5_side;
    logic [PROD_W:0]   r5_num;
    logic [DUR_W:0]    r5_den2;

    always_ff @(posedge i_clk) begin
        r4_seg       <= da_side.seg;
        r4_quo       <= da_quo;
        r4_nz        <= (da_rem != '0);
        r4_dq        <= PROD_W'(da_side.d) * PROD_W'(da_quo);
        r4_dr        <= PROD_W'(da_side.d) * PROD_W'(da_rem);
        r4_ad        <= da_side.ad;
        r4_den       <= da_den;
        r5_side.seg  <= r4_seg;
        r5_side.quo  <= r4_quo;
        r5_side.nz   <= r4_nz;
        r5_side.hdq  <= r4_dq[PROD_W-1:1];
        r5_side.ad   <= r4_ad;
        // odd d*q carries half a divisor into the correction
        r5_num       <= (PROD_W+1)'(r4_dr)
                        + (r4_dq[0] ? (PROD_W+1)'(r4_den) : (PROD_W+1)'(0));
        r5_den2      <= {r4_den, 1'b0};
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r4_v <= da_v;
            r5_v <= r4_v;
        end
    end

    // second division by twice the divisor
    logic              db_v;
    logic [LVL_W-1:0]  db_quo;
    logic [DUR_W:0]    db_rem, db_den;
    logic [SB_W-1:0]   db_side_bits;
    t_side_b           db_side;

    tw_div #(
        .NUM_W  (PROD_W + 1),
        .DEN_W  (DUR_W + 1),
        .Q_W    (LVL_W),
        .SIDE_W (SB_W)
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_num   (r5_num),
        .i_den   (r5_den2),
        .i_side  (SB_W'(r5_side)),
        .o_valid (db_v),
        .o_quo   (db_quo),
        .o_rem   (db_rem),
        .o_den   (db_den),
        .o_side  (db_side_bits)
    );

    assign db_side = t_side_b'(db_side_bits);

    // magnitudes per segment
    logic              r6_v;
    logic              r6_neg;
    logic [LVL_W-1:0]  r6_amp;
    logic [AREA_W-1:0] r6_area;
    logic [LVL_W-1:0]  n6_amp;
    logic [AREA_W-1:0] n6_area;
    logic [AREA_W-1:0] n6_part;
    logic [AREA_W-1:0] n6_fall;

    always_comb begin
        n6_part = AREA_W'(db_side.hdq) + AREA_W'(db_quo);
        n6_fall = AREA_W'(cfg.base) + AREA_W'(db_side.ad) - n6_part;
        n6_amp  = '0;
        n6_area = '0;
        case (db_side.seg)
            SEG_RISE: begin
                n6_amp  = db_side.quo;
                n6_area = n6_part;
            end
            SEG_PLAT: begin
                n6_amp  = cfg.mag;
                n6_area = AREA_W'(cfg.half_ar) + AREA_W'(db_side.ad);
            end
            SEG_FALL: begin
                n6_amp  = cfg.mag - db_side.quo - LVL_W'(db_side.nz);
                n6_area = n6_fall;
            end
            SEG_DONE: begin
                n6_area = cfg.f_zero ? AREA_W'(cfg.base) : n6_fall;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r6_amp      <= n6_amp;
        r6_area     <= n6_area;
        r6_neg      <= cfg.neg;
        o_amplitude <= r6_neg ? (~r6_amp + LVL_W'(1)) : r6_amp;
        o_area      <= r6_neg ? (~r6_area + AREA_W'(1)) : r6_area;
        if (!i_rst_n) begin
            r6_v    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r6_v    <= db_v;
            o_valid <= r6_v;
        end
    end

    // remainder and divisor of the second division are not needed
    logic unused_db;
    assign unused_db = ^{db_rem, db_den};

endmodule

>>> design/tw_cfg.sv
// configuration registers and the break points and products derived from them
module tw_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tw_pkg::t_cfg                  o_cfg
);
    import tw_pkg::*;

    logic [START_W-1:0] r_start;
    logic [DUR_W-1:0]   r_rise;
    logic [DUR_W-1:0]   r_plat;
    logic [DUR_W-1:0]   r_fall;
    logic [LVL_W-1:0]   r_peak;

    logic [TIME_W-1:0]  r_t0, r_t1, r_t2, r_t3;
    logic [LVL_W-1:0]   r_mag;
    logic               r_neg;
    logic [PROD_W-1:0]  r_ar, r_ap;
    logic [PROD_W-2:0]  r_half_ar;
    logic [PROD_W:0]    r_base;

    logic [TIME_W-1:0]  n_t1, n_t2, n_t3;
    logic [LVL_W-1:0]   n_mag;

    always_comb begin
        n_t1  = TIME_W'(r_start) + TIME_W'(r_rise);
        n_t2  = n_t1 + TIME_W'(r_plat);
        n_t3  = n_t2 + TIME_W'(r_fall);
        n_mag = r_peak[LVL_W-1] ? (~r_peak + LVL_W'(1)) : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_rise    <= '0;
            r_plat    <= '0;
            r_fall    <= '0;
            r_peak    <= '0;
            r_t0      <= '0;
            r_t1      <= '0;
            r_t2      <= '0;
            r_t3      <= '0;
            r_mag     <= '0;
            r_neg     <= 1'b0;
            r_ar      <= '0;
            r_ap      <= '0;
            r_half_ar <= '0;
            r_base    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_START: r_start <= i_cfg_data;
                    REG_RISE:  r_rise  <= i_cfg_data[DUR_W-1:0];
                    REG_PLAT:  r_plat  <= i_cfg_data[DUR_W-1:0];
                    REG_FALL:  r_fall  <= i_cfg_data[DUR_W-1:0];
                    REG_PEAK:  r_peak  <= i_cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end
            r_t0      <= TIME_W'(r_start);
            r_t1      <= n_t1;
            r_t2      <= n_t2;
            r_t3      <= n_t3;
            r_mag     <= n_mag;
            r_neg     <= r_peak[LVL_W-1];
            r_ar      <= PROD_W'(r_mag) * PROD_W'(r_rise);
            r_ap      <= PROD_W'(r_mag) * PROD_W'(r_plat);
            r_half_ar <= r_ar[PROD_W-1:1];
            r_base    <= (PROD_W+1)'(r_ar[PROD_W-1:1]) + (PROD_W+1)'(r_ap);
        end
    end

    always_comb begin
        o_cfg.t0      = r_t0;
        o_cfg.t1      = r_t1;
        o_cfg.t2      = r_t2;
        o_cfg.t3      = r_t3;
        o_cfg.rise    = r_rise;
        o_cfg.fall    = r_fall;
        o_cfg.mag     = r_mag;
        o_cfg.neg     = r_neg;
        o_cfg.f_zero  = (r_fall == '0);
        o_cfg.half_ar = r_half_ar;
        o_cfg.base    = r_base;
    end

endmodule

>>> design/tw_div.sv
// pipelined restoring divider, one quotient bit per stage
module tw_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 24,
    parameter int Q_W    = 24,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic [DEN_W-1:0]  o_rem,
    output logic [DEN_W-1:0]  o_den,
    output logic [SIDE_W-1:0] o_side
);
    // numerator high part must already be below the divisor

    logic              r_v    [Q_W];
    logic [DEN_W-1:0]  r_rem  [Q_W];
    logic [Q_W-1:0]    r_low  [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    logic              n_v    [Q_W];
    logic [DEN_W-1:0]  n_rem  [Q_W];
    logic [Q_W-1:0]    n_low  [Q_W];
    logic [Q_W-1:0]    n_quo  [Q_W];
    logic [DEN_W-1:0]  n_den  [Q_W];
    logic [SIDE_W-1:0] n_side [Q_W];

    always_comb begin
        logic [DEN_W-1:0] prem;
        logic [Q_W-1:0]   plow;
        logic [Q_W-1:0]   pquo;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                n_v[k]    = i_valid;
                prem      = i_num[NUM_W-1 -: DEN_W];
                plow      = i_num[Q_W-1:0];
                pquo      = '0;
                n_den[k]  = i_den;
                n_side[k] = i_side;
            end else begin
                n_v[k]    = r_v[k-1];
                prem      = r_rem[k-1];
                plow      = r_low[k-1];
                pquo      = r_quo[k-1];
                n_den[k]  = r_den[k-1];
                n_side[k] = r_side[k-1];
            end
            trial = {prem, plow[Q_W-1]};
            diff  = trial - {1'b0, n_den[k]};
            if (trial >= {1'b0, n_den[k]}) begin
                n_rem[k] = diff[DEN_W-1:0];
                n_quo[k] = {pquo[Q_W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[DEN_W-1:0];
                n_quo[k] = {pquo[Q_W-2:0], 1'b0};
            end
            n_low[k] = {plow[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_W; k++) begin
            r_rem[k]  <= n_rem[k];
            r_low[k]  <= n_low[k];
            r_quo[k]  <= n_quo[k];
            r_den[k]  <= n_den[k];
            r_side[k] <= n_side[k];
        end
        if (!i_rst_n) begin
            for (int k = 0; k < Q_W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < Q_W; k++) begin
                r_v[k] <= n_v[k];
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_rem   = r_rem[Q_W-1];
    assign o_den   = r_den[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule
